>>> rtl/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared constants, types and tables of the two-link arm IK pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int unsigned AngleFracBits = 6;
  localparam int unsigned CordicStages  = 16;
  localparam int unsigned IntFrac       = 22;
  localparam int unsigned TabLen        = 24;

  // register indexes
  localparam logic [2:0] RegUpper   = 3'd0;
  localparam logic [2:0] RegLower   = 3'd1;
  localparam logic [2:0] RegShMin   = 3'd2;
  localparam logic [2:0] RegShMax   = 3'd3;
  localparam logic [2:0] RegElMin   = 3'd4;
  localparam logic [2:0] RegElMax   = 3'd5;
  localparam logic [2:0] RegShTrim  = 3'd6;
  localparam logic [2:0] RegElTrim  = 3'd7;

  // status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUnreach = 2'd1;
  localparam logic [1:0] StShRange = 2'd2;
  localparam logic [1:0] StElRange = 2'd3;

  // one CORDIC lane: 34 bit vector (magnitude kept below 2^32), 40 bit angle
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [39:0] z;
  } lane_t;

  function automatic logic signed [39:0] atan_entry(input int unsigned i);
    logic signed [39:0] r;
    case (i)
      0: r = 40'sd188743680;  1: r = 40'sd111421900;  2: r = 40'sd58872272;
      3: r = 40'sd29884485;   4: r = 40'sd15000234;   5: r = 40'sd7507429;
      6: r = 40'sd3754631;    7: r = 40'sd1877430;    8: r = 40'sd938729;
      9: r = 40'sd469366;    10: r = 40'sd234683;    11: r = 40'sd117342;
      12: r = 40'sd58671;    13: r = 40'sd29335;     14: r = 40'sd14668;
      15: r = 40'sd7334;     16: r = 40'sd3667;      17: r = 40'sd1833;
      18: r = 40'sd917;      19: r = 40'sd458;       20: r = 40'sd229;
      21: r = 40'sd115;      22: r = 40'sd57;        23: r = 40'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

  // +-90 degree pre-rotation then normalize to [2^29, 2^30)
  function automatic lane_t cordic_prep(input logic signed [63:0] xi,
                                        input logic signed [63:0] yi);
    logic signed [63:0] x, y, t;
    logic [63:0] mx, my, m;
    logic signed [39:0] z;
    int unsigned lz;
    lane_t r;
    x = xi; y = yi; z = '0;
    if (x < 0) begin
      if (y >= 0) begin t = y; y = -x; x = t; z = 40'sd90 <<< IntFrac; end
      else begin t = -y; y = x; x = t; z = -(40'sd90 <<< IntFrac); end
    end
    mx = (x < 0) ? 64'(-x) : 64'(x);
    my = (y < 0) ? 64'(-y) : 64'(y);
    m  = (mx > my) ? mx : my;
    lz = 0;
    for (int k = 0; k < 64; k++) if (m[k]) lz = k;
    if (m == 0) begin
      r.x = '0; r.y = '0;
    end else if (lz >= 30) begin
      r.x = 34'(x >>> (lz - 29)); r.y = 34'(y >>> (lz - 29));
    end else begin
      r.x = 34'(x <<< (29 - lz)); r.y = 34'(y <<< (29 - lz));
    end
    r.z = (m == 0) ? 40'sd0 : z;
    return r;
  endfunction

endpackage

>>> rtl/tlik_cell.sv
// ----------------------------------------------------------------------------
// tlik_cell
// One CORDIC micro-rotation for three lanes plus a sideband payload.
// ----------------------------------------------------------------------------
module tlik_cell #(
  parameter int unsigned Stage = 0,
  parameter int unsigned SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  tlik_pkg::lane_t      lane_i [3],
  input  logic [SideW-1:0]     side_i,
  output logic                 vld_o,
  output tlik_pkg::lane_t      lane_o [3],
  output logic [SideW-1:0]     side_o
);
  import tlik_pkg::*;

  logic vld_q;
  lane_t lane_q [3];
  logic [SideW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      for (int k = 0; k < 3; k++) begin
        if (lane_i[k].y >= 0) begin
          lane_q[k].x <= lane_i[k].x + (lane_i[k].y >>> Stage);
          lane_q[k].y <= lane_i[k].y - (lane_i[k].x >>> Stage);
          lane_q[k].z <= lane_i[k].z + atan_entry(Stage);
        end else begin
          lane_q[k].x <= lane_i[k].x - (lane_i[k].y >>> Stage);
          lane_q[k].y <= lane_i[k].y + (lane_i[k].x >>> Stage);
          lane_q[k].z <= lane_i[k].z - atan_entry(Stage);
        end
      end
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;
  assign side_o = side_q;
endmodule

>>> rtl/two_link_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics
// Pipelined two-link planar inverse kinematics with a chain of CORDIC cells.
// ----------------------------------------------------------------------------
// Usage: targets enter on s_axis (tdata = target_x, target_y). Each transfer
// yields one result on m_axis (tdata = status, shoulder, elbow angles and
// servo commands). Link lengths, joint limits and trims are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no
// item is in flight; the block does not enforce it. Throughput: one item per
// cycle while the receiver does not stall. Stages: 5 setup stages (squares,
// the area product and its shift), 8 square-root stages of up to four steps
// each, the CORDIC pre-rotation stage, CordicStages cells and 2 output
// stages, so 32 register stages with the default 16 cells. The whole
// pipeline advances only when the output register is free or being taken,
// so a stalled receiver holds every stage; s_axis_tready follows that
// enable. Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics #(
  parameter int unsigned CordicStages = tlik_pkg::CordicStages
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [18:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // target_x[19:0], target_y[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // status, shoulder, elbow, sh cmd, el cmd
);
  import tlik_pkg::*;

  localparam int unsigned Rs = IntFrac - AngleFracBits;

  logic [18:0] upper_q, lower_q;
  logic signed [15:0] sh_min_q, sh_max_q, el_min_q, el_max_q;
  logic signed [14:0] sh_trim_q, el_trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0; lower_q <= '0;
      sh_min_q <= '0; sh_max_q <= 16'sd11520;
      el_min_q <= '0; el_max_q <= 16'sd11520;
      sh_trim_q <= '0; el_trim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUpper:  upper_q   <= cfg_data_i;
        RegLower:  lower_q   <= cfg_data_i;
        RegShMin:  sh_min_q  <= cfg_data_i[15:0];
        RegShMax:  sh_max_q  <= cfg_data_i[15:0];
        RegElMin:  el_min_q  <= cfg_data_i[15:0];
        RegElMax:  el_max_q  <= cfg_data_i[15:0];
        RegShTrim: sh_trim_q <= cfg_data_i[14:0];
        RegElTrim: el_trim_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic ovld_q;
  assign en = !ovld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: squares
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [19:0] x1_q, y1_q;
  logic [39:0] xx1_q, yy1_q;
  logic [19:0] sum1_q, dif1_q;
  logic z1_q;
  // stage 2
  logic signed [19:0] x2_q, y2_q;
  logic [40:0] d2_2_q;
  logic [39:0] ss2_q, dd2_q, aa2_q, bb2_q;
  logic z2_q;
  // stage 3: t, u, p, q, unreachable
  logic signed [19:0] x3_q, y3_q;
  logic [40:0] t3_q, u3_q;
  logic signed [42:0] p3_q, q3_q;
  logic un3_q;
  // stage 4: K = t*u split into four 21x21 partial products
  logic signed [19:0] x4_q, y4_q;
  logic [41:0] pll4_q, plh4_q, phl4_q, phh4_q;
  logic signed [42:0] p4_q, q4_q;
  logic un4_q;
  // stage 5: K and shift
  logic signed [19:0] x5_q, y5_q;
  logic [61:0] k5_q;
  logic signed [42:0] p5_q, q5_q;
  logic un5_q;

  logic [81:0] kfull;
  logic [5:0] hcnt;
  always_comb begin
    kfull = {40'd0, pll4_q} + ({40'd0, plh4_q} << 21) + ({40'd0, phl4_q} << 21)
            + ({40'd0, phh4_q} << 42);
    hcnt = '0;
    for (int k = 1; k <= 10; k++) if ((kfull >> (2*k - 2)) >= (82'd1 << 62)) hcnt = 6'(k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q} <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= s_axis_tdata[19:0]; y1_q <= s_axis_tdata[39:20];
      xx1_q <= 40'($signed(s_axis_tdata[19:0]) * $signed(s_axis_tdata[19:0]));
      yy1_q <= 40'($signed(s_axis_tdata[39:20]) * $signed(s_axis_tdata[39:20]));
      sum1_q <= 20'(upper_q) + 20'(lower_q);
      dif1_q <= (upper_q > lower_q) ? 20'(upper_q - lower_q) : 20'(lower_q - upper_q);
      z1_q <= (upper_q == 0) || (lower_q == 0);

      x2_q <= x1_q; y2_q <= y1_q; z2_q <= z1_q;
      d2_2_q <= 41'(xx1_q) + 41'(yy1_q);
      ss2_q <= sum1_q * sum1_q; dd2_q <= dif1_q * dif1_q;
      aa2_q <= 40'(upper_q) * 40'(upper_q); bb2_q <= 40'(lower_q) * 40'(lower_q);

      x3_q <= x2_q; y3_q <= y2_q;
      un3_q <= z2_q || (d2_2_q == 0) || (d2_2_q > 41'(ss2_q)) || (d2_2_q < 41'(dd2_q));
      t3_q <= d2_2_q - 41'(dd2_q);
      u3_q <= 41'(ss2_q) - d2_2_q;
      p3_q <= 43'(d2_2_q) + 43'(aa2_q) - 43'(bb2_q);
      q3_q <= 43'(aa2_q) + 43'(bb2_q) - 43'(d2_2_q);

      x4_q <= x3_q; y4_q <= y3_q; un4_q <= un3_q; p4_q <= p3_q; q4_q <= q3_q;
      pll4_q <= t3_q[20:0] * u3_q[20:0];
      plh4_q <= t3_q[20:0] * {1'b0, u3_q[40:21]};
      phl4_q <= {1'b0, t3_q[40:21]} * u3_q[20:0];
      phh4_q <= {1'b0, t3_q[40:21]} * {1'b0, u3_q[40:21]};

      x5_q <= x4_q; y5_q <= y4_q; un5_q <= un4_q;
      k5_q <= 62'(kfull >> (2 * hcnt));
      p5_q <= p4_q >>> hcnt;
      q5_q <= q4_q >>> hcnt;
    end
  end

  // square root, up to four restoring steps per stage
  localparam int unsigned SqSteps    = 31;
  localparam int unsigned SqPerStage = 4;
  localparam int unsigned SqStages   = (SqSteps + SqPerStage - 1) / SqPerStage;

  // returns {remainder, partial root}
  function automatic logic [127:0] sqrt_steps(input logic [63:0] ni,
                                             input logic [63:0] ri,
                                             input int unsigned first);
    logic [63:0] n, res, b;
    n = ni;
    res = ri;
    b = '0;
    for (int unsigned k = 0; k < SqPerStage; k++) begin
      if (first + k < SqSteps) begin
        b = 64'd1 << (60 - 2 * (first + k));
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
      end
    end
    return {n, res};
  endfunction

  logic               sq_v_q  [SqStages];
  logic               sq_un_q [SqStages];
  logic signed [19:0] sq_x_q  [SqStages];
  logic signed [19:0] sq_y_q  [SqStages];
  logic signed [42:0] sq_p_q  [SqStages];
  logic signed [42:0] sq_q_q  [SqStages];
  logic [63:0]        sq_n_q  [SqStages];
  logic [63:0]        sq_r_q  [SqStages];

  for (genvar g = 0; g < SqStages; g++) begin : g_sqrt
    logic               v_in, un_in;
    logic signed [19:0] x_in, y_in;
    logic signed [42:0] p_in, q_in;
    logic [63:0]        n_in, r_in;
    logic [127:0]       step;
    if (g == 0) begin : g_src
      assign v_in  = v5_q;
      assign un_in = un5_q;
      assign x_in  = x5_q;
      assign y_in  = y5_q;
      assign p_in  = p5_q;
      assign q_in  = q5_q;
      assign n_in  = 64'(k5_q);
      assign r_in  = '0;
    end else begin : g_src
      assign v_in  = sq_v_q[g-1];
      assign un_in = sq_un_q[g-1];
      assign x_in  = sq_x_q[g-1];
      assign y_in  = sq_y_q[g-1];
      assign p_in  = sq_p_q[g-1];
      assign q_in  = sq_q_q[g-1];
      assign n_in  = sq_n_q[g-1];
      assign r_in  = sq_r_q[g-1];
    end
    assign step = sqrt_steps(n_in, r_in, g * SqPerStage);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[g] <= 1'b0;
      else if (en) sq_v_q[g] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_un_q[g] <= un_in;
        sq_x_q[g]  <= x_in;
        sq_y_q[g]  <= y_in;
        sq_p_q[g]  <= p_in;
        sq_q_q[g]  <= q_in;
        sq_n_q[g]  <= step[127:64];
        sq_r_q[g]  <= step[63:0];
      end
    end
  end

  logic [30:0] sroot;
  assign sroot = sq_r_q[SqStages-1][30:0];

  localparam int unsigned SideW = 1;
  lane_t lane [CordicStages+1][3];
  logic  vld  [CordicStages+1];
  logic [SideW-1:0] side [CordicStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld[0] <= 1'b0;
    else if (en) vld[0] <= sq_v_q[SqStages-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      side[0] <= sq_un_q[SqStages-1];
      lane[0][0] <= cordic_prep(64'(sq_x_q[SqStages-1]), 64'(sq_y_q[SqStages-1]));
      lane[0][1] <= cordic_prep(64'(sq_p_q[SqStages-1]), 64'(sroot));
      lane[0][2] <= cordic_prep(64'(sq_q_q[SqStages-1]), 64'(sroot));
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    tlik_cell #(.Stage(g), .SideW(SideW)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .vld_i(vld[g]), .lane_i(lane[g]),
      .side_i(side[g]), .vld_o(vld[g+1]), .lane_o(lane[g+1]), .side_o(side[g+1])
    );
  end

  // output stages
  logic v7_q;
  logic signed [40:0] so7_q, eo7_q;
  logic un7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0; ovld_q <= 1'b0;
    end else if (en) begin
      v7_q <= vld[CordicStages]; ovld_q <= v7_q;
    end
  end

  logic signed [40:0] shz, elz;
  always_comb begin
    shz = 41'(lane[CordicStages][0].z) + 41'(lane[CordicStages][1].z);
    elz = shz + 41'(lane[CordicStages][2].z) - (41'sd90 <<< IntFrac);
  end

  function automatic logic [15:0] sat16(input logic signed [41:0] v);
    if (v > 42'sd32767) return 16'h7fff;
    if (v < -42'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  logic [1:0] st;
  logic [71:0] odata_d, odata_q;
  always_comb begin
    if (un7_q) st = StUnreach;
    else if (so7_q < 41'(sh_min_q) || so7_q > 41'(sh_max_q)) st = StShRange;
    else if (eo7_q < 41'(el_min_q) || eo7_q > 41'(el_max_q)) st = StElRange;
    else st = StOk;
  end

  always_comb begin
    odata_d = '0;
    odata_d[1:0] = st;
    if (!un7_q) begin
      odata_d[17:2]  = sat16(42'(so7_q));
      odata_d[33:18] = sat16(42'(eo7_q));
    end
    if (st == StOk) begin
      odata_d[49:34] = sat16(42'(so7_q) - 42'(sh_trim_q));
      odata_d[65:50] = sat16((42'sd180 <<< AngleFracBits) - 42'(eo7_q)
                             - 42'(el_trim_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      un7_q <= side[CordicStages][0];
      so7_q <= (shz + (41'sd1 <<< (Rs - 1))) >>> Rs;
      eo7_q <= (elz + (41'sd1 <<< (Rs - 1))) >>> Rs;
      odata_q <= odata_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready |=> ovld_q && $stable(odata_q))
    else $error("result changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ovld_q |-> s_axis_tready) else $error("blocked with empty output");
  a_unr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && odata_q[1:0] == StUnreach |-> odata_q[65:2] == '0)
    else $error("unreachable result not cleared");
endmodule
